@@ sv/ptc_pkg.sv @@
// Shared types, constants and helpers for the pressure and temperature compensation pipeline.
package ptc_pkg;

	typedef logic [63:0] u64_t;
	typedef logic [31:0] u32_t;

	// Configuration register indexes
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t REG_TEMP_CAL  = 2'd0;
	localparam cfg_idx_t REG_PRESS_LO  = 2'd1;
	localparam cfg_idx_t REG_PRESS_HI  = 2'd2;
	localparam cfg_idx_t REG_PRESS_P9  = 2'd3;

	// Compensation constants
	localparam u64_t K_FINE_OFFSET = 64'd128000;
	localparam u64_t K_PRESS_BASE  = 64'd1048576;
	localparam u64_t K_PRESS_SCALE = 64'd3125;
	localparam u32_t K_CENTI_ROUND = 32'd128;
	localparam int unsigned P4_SHIFT      = 35;
	localparam int unsigned P1_BIAS_SHIFT = 47;

	// Quotient bits resolved, one per divider stage
	localparam int unsigned DIV_STEPS = 64;

	// Sign-extend a 16-bit calibration slice
	function automatic u64_t sx16_64(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic u32_t sx16_32(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

@@ sv/ptc_delay.sv @@
// Enabled shift line that carries a value alongside the pipeline.
module ptc_delay #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] line_q [0:DEPTH-1];

	// shift one place per advance
	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[DEPTH-1];

endmodule

@@ sv/ptc_mul64.sv @@
// Two-stage 64 x 64 multiplier, product kept modulo 2^64.
module ptc_mul64 (
	input  logic           clk,
	input  logic           en,
	input  ptc_pkg::u64_t  a,
	input  ptc_pkg::u64_t  b,
	output ptc_pkg::u64_t  p
);
	import ptc_pkg::*;

	u64_t ll_s1;
	u32_t lh_s1;
	u32_t hl_s1;
	u64_t p_s2;
	u64_t ll;
	u32_t lh;
	u32_t hl;

	// partial products; high x high falls outside 64 bits
	assign ll = a[31:0] * b[31:0];
	assign lh = a[31:0] * b[63:32];
	assign hl = a[63:32] * b[31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= ll;
			lh_s1 <= lh;
			hl_s1 <= hl;
			p_s2  <= ll_s1 + {lh_s1 + hl_s1, 32'd0};
		end
	end

	assign p = p_s2;

endmodule

@@ sv/ptc_sdiv.sv @@
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating toward zero.
module ptc_sdiv (
	input  logic           clk,
	input  logic           en,
	input  ptc_pkg::u64_t  num,
	input  ptc_pkg::u64_t  den,
	output ptc_pkg::u64_t  quo
);
	import ptc_pkg::*;

	u64_t rem_s [0:DIV_STEPS];
	u64_t dvd_s [0:DIV_STEPS];
	u64_t den_s [0:DIV_STEPS];
	logic neg_s [0:DIV_STEPS];
	u64_t quo_s;

	// magnitudes and result sign
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			dvd_s[0] <= num[63] ? (64'd0 - num) : num;
			den_s[0] <= den[63] ? (64'd0 - den) : den;
			neg_s[0] <= num[63] ^ den[63];
		end
	end

	// restoring steps; quotient bits shift in behind the dividend
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [64:0] trial;
		logic [64:0] diff;
		assign trial = {rem_s[k], dvd_s[k][63]};
		assign diff  = trial - {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= diff[64] ? trial[63:0] : diff[63:0];
				dvd_s[k+1] <= {dvd_s[k][62:0], ~diff[64]};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	// sign fix-up; most negative by -1 wraps naturally
	always_ff @(posedge clk) begin
		if (en) begin
			quo_s <= neg_s[DIV_STEPS] ? (64'd0 - dvd_s[DIV_STEPS]) : dvd_s[DIV_STEPS];
		end
	end

	assign quo = quo_s;

endmodule

@@ sv/pressure_temperature_compensation.sv @@
// Throughput: one word per cycle; the whole pipeline holds while a result is stalled.
// Depth is set by the 66-stage bit-per-stage pressure divider and the two-stage multipliers.
// Reset clears the valid bits and all calibration registers; data registers are not reset.
module pressure_temperature_compensation (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [19:0]          raw_temperature,
	input  logic [19:0]          raw_pressure,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   fine_temperature,
	output logic signed [31:0]   temperature_centi,
	output logic [31:0]          pressure_q24_8,
	output logic                 pressure_invalid,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  ptc_pkg::cfg_idx_t    cfg_index,
	input  ptc_pkg::u64_t        cfg_data
);
	import ptc_pkg::*;

	localparam int unsigned LATENCY = 87;

	logic adv;
	logic vld_q [1:LATENCY];

	logic [47:0] tcal_q;
	u64_t        pcal_lo_q;
	u64_t        pcal_hi_q;
	logic [15:0] p9_q;

	u32_t t1, t2, t3;
	u64_t p1, p2, p3, p4, p5, p6, p7, p8, p9;

	logic [19:0] raw_t_s1, raw_p_s1;
	u32_t tx, td;
	u32_t ma_s2, dd_s2;
	u32_t a_s3, mb_s3;
	u32_t fine_s4;
	u32_t cr;
	u32_t centi_s5;
	u64_t v1_s5;

	u64_t sq_s7, q5_s7, q2_s7;
	u64_t pa_s9, pd_s9, q5_s9, q2_s9;
	u64_t v2_s10, v1b_s10, v2_s12, g3_s12;
	logic [19:0] adcp_s12;
	u64_t f_s13, num_pre_s13;
	u64_t num_s15, f_s15;
	logic inv_s86, inv_s87;
	u64_t q_s81, q_s83, q_s85;
	u64_t ph_s81, ph_s83;
	u64_t p9ph_s83, p8p_s83, w1_s85, w2_s85;
	u64_t sum_s86;
	u64_t pfin;
	u32_t press_s87;
	u32_t fine_s87, centi_s87;

	// the pipeline moves whenever the output register is free or being taken
	assign adv       = !vld_q[LATENCY] || !out_stall;
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;

	// calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcal_q    <= '0;
			pcal_lo_q <= '0;
			pcal_hi_q <= '0;
			p9_q      <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TEMP_CAL: tcal_q    <= cfg_data[47:0];
				REG_PRESS_LO: pcal_lo_q <= cfg_data;
				REG_PRESS_HI: pcal_hi_q <= cfg_data;
				REG_PRESS_P9: p9_q      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// calibration word slices
	assign t1 = {16'd0, tcal_q[15:0]};
	assign t2 = sx16_32(tcal_q[31:16]);
	assign t3 = sx16_32(tcal_q[47:32]);
	assign p1 = {48'd0, pcal_lo_q[15:0]};
	assign p2 = sx16_64(pcal_lo_q[31:16]);
	assign p3 = sx16_64(pcal_lo_q[47:32]);
	assign p4 = sx16_64(pcal_lo_q[63:48]);
	assign p5 = sx16_64(pcal_hi_q[15:0]);
	assign p6 = sx16_64(pcal_hi_q[31:16]);
	assign p7 = sx16_64(pcal_hi_q[47:32]);
	assign p8 = sx16_64(pcal_hi_q[63:48]);
	assign p9 = sx16_64(p9_q);

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LATENCY; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_q[1] <= in_valid;
			for (int i = 2; i <= LATENCY; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// temperature path, 32-bit wrap
	assign tx = {15'd0, raw_t_s1[19:3]} - {t1[30:0], 1'b0};
	assign td = {16'd0, raw_t_s1[19:4]} - t1;
	assign cr = {fine_s4[29:0], 2'b00} + fine_s4 + K_CENTI_ROUND;

	always_ff @(posedge clk) begin
		if (adv) begin
			raw_t_s1 <= raw_temperature;
			raw_p_s1 <= raw_pressure;
			ma_s2    <= tx * t2;
			dd_s2    <= td * td;
			a_s3     <= u32_t'($signed(ma_s2) >>> 11);
			mb_s3    <= u32_t'($signed(dd_s2) >>> 12) * t3;
			fine_s4  <= a_s3 + u32_t'($signed(mb_s3) >>> 14);
			centi_s5 <= u32_t'($signed(cr) >>> 8);
			v1_s5    <= {{32{fine_s4[31]}}, fine_s4} - K_FINE_OFFSET;
		end
	end

	// v1 squared and linear terms
	ptc_mul64 u_mul_sq (.clk(clk), .en(adv), .a(v1_s5), .b(v1_s5), .p(sq_s7));
	ptc_mul64 u_mul_q5 (.clk(clk), .en(adv), .a(v1_s5), .b(p5), .p(q5_s7));
	ptc_mul64 u_mul_q2 (.clk(clk), .en(adv), .a(v1_s5), .b(p2), .p(q2_s7));

	// quadratic terms
	ptc_mul64 u_mul_p6 (.clk(clk), .en(adv), .a(sq_s7), .b(p6), .p(pa_s9));
	ptc_mul64 u_mul_p3 (.clk(clk), .en(adv), .a(sq_s7), .b(p3), .p(pd_s9));
	ptc_delay #(.WIDTH(64), .DEPTH(2)) u_dl_q5 (.clk(clk), .en(adv), .d(q5_s7), .q(q5_s9));
	ptc_delay #(.WIDTH(64), .DEPTH(2)) u_dl_q2 (.clk(clk), .en(adv), .d(q2_s7), .q(q2_s9));

	always_ff @(posedge clk) begin
		if (adv) begin
			v2_s10  <= pa_s9 + (q5_s9 << 17) + (p4 << P4_SHIFT);
			v1b_s10 <= u64_t'($signed(pd_s9) >>> 8) + (q2_s9 << 12);
		end
	end

	// divisor scaling by P1
	ptc_mul64 u_mul_p1 (
		.clk(clk), .en(adv),
		.a((64'd1 << P1_BIAS_SHIFT) + v1b_s10), .b(p1), .p(g3_s12)
	);
	ptc_delay #(.WIDTH(64), .DEPTH(2))  u_dl_v2 (.clk(clk), .en(adv), .d(v2_s10), .q(v2_s12));
	ptc_delay #(.WIDTH(20), .DEPTH(11)) u_dl_ap (.clk(clk), .en(adv), .d(raw_p_s1), .q(adcp_s12));

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s13       <= u64_t'($signed(g3_s12) >>> 33);
			num_pre_s13 <= ((K_PRESS_BASE - {44'd0, adcp_s12}) << 31) - v2_s12;
		end
	end

	// dividend scaling
	ptc_mul64 u_mul_sc (.clk(clk), .en(adv), .a(num_pre_s13), .b(K_PRESS_SCALE), .p(num_s15));
	ptc_delay #(.WIDTH(64), .DEPTH(2)) u_dl_f (.clk(clk), .en(adv), .d(f_s13), .q(f_s15));
	ptc_delay #(.WIDTH(1), .DEPTH(71)) u_dl_inv (
		.clk(clk), .en(adv), .d(f_s15 == 64'd0), .q(inv_s86)
	);

	// pressure division
	ptc_sdiv u_div (.clk(clk), .en(adv), .num(num_s15), .den(f_s15), .quo(q_s81));

	// second-order correction
	assign ph_s81 = u64_t'($signed(q_s81) >>> 13);
	assign ph_s83 = u64_t'($signed(q_s83) >>> 13);
	ptc_mul64 u_mul_p9 (.clk(clk), .en(adv), .a(p9), .b(ph_s81), .p(p9ph_s83));
	ptc_mul64 u_mul_p8 (.clk(clk), .en(adv), .a(p8), .b(q_s81), .p(p8p_s83));
	ptc_delay #(.WIDTH(64), .DEPTH(2)) u_dl_q83 (.clk(clk), .en(adv), .d(q_s81), .q(q_s83));
	ptc_mul64 u_mul_ph (.clk(clk), .en(adv), .a(p9ph_s83), .b(ph_s83), .p(w1_s85));
	ptc_delay #(.WIDTH(64), .DEPTH(2)) u_dl_w2 (
		.clk(clk), .en(adv), .d(u64_t'($signed(p8p_s83) >>> 19)), .q(w2_s85)
	);
	ptc_delay #(.WIDTH(64), .DEPTH(2)) u_dl_q85 (.clk(clk), .en(adv), .d(q_s83), .q(q_s85));

	// temperature results ride alongside
	ptc_delay #(.WIDTH(32), .DEPTH(83)) u_dl_fine (
		.clk(clk), .en(adv), .d(fine_s4), .q(fine_s87)
	);
	ptc_delay #(.WIDTH(32), .DEPTH(82)) u_dl_centi (
		.clk(clk), .en(adv), .d(centi_s5), .q(centi_s87)
	);

	assign pfin = u64_t'($signed(sum_s86) >>> 8) + (p7 << 4);

	// final sum and output word
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s86   <= q_s85 + u64_t'($signed(w1_s85) >>> 25) + w2_s85;
			press_s87 <= inv_s86 ? 32'd0 : pfin[31:0];
			inv_s87   <= inv_s86;
		end
	end

	assign out_valid         = vld_q[LATENCY];
	assign fine_temperature  = $signed(fine_s87);
	assign temperature_centi = $signed(centi_s87);
	assign pressure_q24_8    = press_s87;
	assign pressure_invalid  = inv_s87;

endmodule

@@ sim/tb_top.sv @@
// Testbench for the pressure and temperature compensation pipeline.
`timescale 1ns / 1ps

module tb_top;
	import ptc_pkg::*;

	localparam int LATENCY = 87;

	typedef struct packed {
		logic [19:0] raw_t;
		logic [19:0] raw_p;
	} sample_t;

	typedef struct packed {
		logic [31:0] fine;
		logic [31:0] centi;
		logic [31:0] press;
		logic        invalid;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [19:0] raw_temperature = '0;
	logic [19:0] raw_pressure = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] fine_temperature;
	logic signed [31:0] temperature_centi;
	logic [31:0] pressure_q24_8;
	logic pressure_invalid;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_idx_t cfg_index = REG_TEMP_CAL;
	u64_t cfg_data = '0;

	// Calibration copy held by the predictor
	logic [47:0] cal_temp;
	logic [63:0] cal_press_lo;
	logic [63:0] cal_press_hi;
	logic [15:0] cal_p9;

	sample_t  pending_samples[$];
	reading_t expected_readings[$];
	int errors = 0;
	bit quiet = 1'b0;
	bit hold_sender = 1'b0;

	pressure_temperature_compensation dut (.*);

	always #4 clk = ~clk;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		errors++;
	endtask

	// Compensation predictor: 32-bit temperature path, 64-bit pressure path
	function automatic reading_t compensate(input sample_t s);
		reading_t r;
		logic signed [31:0] t1, t2, t3, adc_t, a, d, b, fine;
		logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic signed [63:0] v1, v2, p, ph, w1, w2, n;
		adc_t = {12'd0, s.raw_t};
		t1 = {16'd0, cal_temp[15:0]};
		t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
		t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
		p1 = {48'd0, cal_press_lo[15:0]};
		p2 = {{48{cal_press_lo[31]}}, cal_press_lo[31:16]};
		p3 = {{48{cal_press_lo[47]}}, cal_press_lo[47:32]};
		p4 = {{48{cal_press_lo[63]}}, cal_press_lo[63:48]};
		p5 = {{48{cal_press_hi[15]}}, cal_press_hi[15:0]};
		p6 = {{48{cal_press_hi[31]}}, cal_press_hi[31:16]};
		p7 = {{48{cal_press_hi[47]}}, cal_press_hi[47:32]};
		p8 = {{48{cal_press_hi[63]}}, cal_press_hi[63:48]};
		p9 = {{48{cal_p9[15]}}, cal_p9};
		a = (((adc_t >> 3) - (t1 << 1)) * t2) >>> 11;
		d = (adc_t >> 4) - t1;
		b = (((d * d) >>> 12) * t3) >>> 14;
		fine = a + b;
		r.fine = fine;
		r.centi = (fine * 32'sd5 + 32'sd128) >>> 8;
		v1 = 64'(fine) - 64'sd128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) <<< 17);
		v2 = v2 + (p4 <<< 35);
		v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
		v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
		r.press = '0;
		r.invalid = 1'b0;
		if (v1 == 0) begin
			r.invalid = 1'b1;
		end else begin
			p = 64'sd1048576 - 64'(s.raw_p);
			n = ((p <<< 31) - v2) * 64'sd3125;
			// most negative over minus one wraps back to itself
			if (n == {1'b1, 63'd0} && v1 == -64'sd1)
				p = n;
			else
				p = n / v1;
			ph = p >>> 13;
			w1 = (p9 * ph * ph) >>> 25;
			w2 = (p8 * p) >>> 19;
			p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
			r.press = p[31:0];
		end
		return r;
	endfunction

	// Driver: one word per handshake from the pending queue
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (pending_samples.size() > 0 && !hold_sender &&
				    (quiet || $urandom_range(99) >= 29)) begin
					sample_t s;
					s = pending_samples.pop_front();
					raw_temperature <= s.raw_t;
					raw_pressure <= s.raw_p;
					in_valid <= 1'b1;
					expected_readings.push_back(compensate(s));
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted result word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				reading_t w;
				if (expected_readings.size() == 0) begin
					report("unexpected word", 0, 0);
				end else begin
					w = expected_readings.pop_front();
					if (fine_temperature !== w.fine)
						report("fine_temperature", fine_temperature, w.fine);
					if (temperature_centi !== w.centi)
						report("temperature_centi", temperature_centi, w.centi);
					if (pressure_q24_8 !== w.press)
						report("pressure_q24_8", pressure_q24_8, w.press);
					if (pressure_invalid !== w.invalid)
						report("pressure_invalid", pressure_invalid, w.invalid);
				end
			end
			out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 29);
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input u64_t v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TEMP_CAL: cal_temp = v[47:0];
			REG_PRESS_LO: cal_press_lo = v;
			REG_PRESS_HI: cal_press_hi = v;
			default: cal_p9 = v[15:0];
		endcase
	endtask

	task automatic configure(input u64_t t, input u64_t lo, input u64_t hi, input u64_t last);
		write_reg(REG_TEMP_CAL, t);
		write_reg(REG_PRESS_LO, lo);
		write_reg(REG_PRESS_HI, hi);
		write_reg(REG_PRESS_P9, last);
	endtask

	task automatic drain();
		wait (pending_samples.size() == 0 && !in_valid && expected_readings.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic u64_t rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Typical calibration with randomised words near datasheet values
	function automatic u64_t typ_temp();
		return {16'(-16'sd1000 + 16'($urandom_range(2000))),
			16'd26000 + 16'($urandom_range(2000)), 16'd27000 + 16'($urandom_range(2000))};
	endfunction

	function automatic u64_t typ_press_lo();
		return {16'd2800 + 16'($urandom_range(400)), 16'd3000 + 16'($urandom_range(600)),
			16'(-16'sd10700 + 16'($urandom_range(400))), 16'd35000 + 16'($urandom_range(3000))};
	endfunction

	function automatic u64_t typ_press_hi();
		return {16'(-16'sd12000 + 16'($urandom_range(200))), 16'd15500 + 16'($urandom_range(200)),
			16'(-16'sd7) - 16'($urandom_range(10)), 16'd140 + 16'($urandom_range(40))};
	endfunction

	// Mostly realistic readings, some full-range noise
	task automatic queue_random(input int count);
		sample_t s;
		repeat (count) begin
			if ($urandom_range(3) != 0) begin
				s.raw_t = 20'd480000 + 20'($urandom_range(120000));
				s.raw_p = 20'd250000 + 20'($urandom_range(200000));
			end else begin
				s.raw_t = 20'($urandom());
				s.raw_p = 20'($urandom());
			end
			pending_samples.push_back(s);
		end
	endtask

	initial begin
		cal_temp = '0;
		cal_press_lo = '0;
		cal_press_hi = '0;
		cal_p9 = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset calibration: every divisor is zero
		pending_samples.push_back('{20'd0, 20'd0});
		pending_samples.push_back('{20'hFFFFF, 20'hFFFFF});
		drain();

		// Datasheet-like calibration with field extremes
		configure(64'hFFFF_FFFF_6A76_6B70, {16'd2855, 16'd3024, -16'sd10685, 16'd36477},
			{16'(-16'sd12000), 16'd15500, -16'sd7, 16'd140}, 64'd6000);
		pending_samples.push_back('{20'd519888, 20'd415148});
		pending_samples.push_back('{20'd0, 20'd0});
		pending_samples.push_back('{20'hFFFFF, 20'hFFFFF});
		pending_samples.push_back('{20'd0, 20'hFFFFF});
		pending_samples.push_back('{20'hFFFFF, 20'd0});
		pending_samples.push_back('{20'h55555, 20'hAAAAA});
		pending_samples.push_back('{20'hAAAAA, 20'h55555});
		// long burst with no idling on either side
		quiet = 1'b1;
		queue_random(200);
		drain();
		quiet = 1'b0;

		// Calibration extremes: all ones, most negative words, most positive words with P1 zero
		configure(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF);
		queue_random(12);
		drain();
		configure(64'h8000_8000_FFFF, 64'h8000_8000_8000_FFFF, 64'h8000_8000_8000_8000, 64'h8000);
		queue_random(12);
		drain();
		configure(64'h7FFF_7FFF_0000, 64'h7FFF_7FFF_7FFF_0000, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF);
		queue_random(12);
		drain();

		// Random and typical settings
		for (int phase = 0; phase < 8; phase++) begin
			if (phase[0])
				configure(rand64(), rand64(), rand64(), rand64());
			else
				configure(typ_temp(), typ_press_lo(), typ_press_hi(), 64'($urandom()));
			queue_random(70);
			// sender holds off until the pipeline is empty
			wait (pending_samples.size() < 35);
			hold_sender = 1'b1;
			wait (expected_readings.size() == 0 && !in_valid);
			hold_sender = 1'b0;
			drain();
		end
		queue_random(595);
		drain();

		if (errors == 0)
			$display("pressure_temperature_compensation test passed");
		else
			$display("pressure_temperature_compensation test failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("pressure_temperature_compensation test failed");
		$finish;
	end

endmodule
